// File: sv/wrrap_pkg.sv
// Shared types and constants of the weighted round-robin address pool.
// Used by the channel interfaces, the entry memory, the core and the checker.
package wrrap_pkg;

  localparam int OpW     = 2;
  localparam int PoolW   = 5;
  localparam int CoreW   = 3;
  localparam int EntryW  = 6;
  localparam int AddrW   = 64;
  localparam int WeightW = 16;
  localparam int PortW   = 16;
  localparam int TotalW  = 7;

  localparam int POOLS_DEF   = 32;
  localparam int CORES_DEF   = 8;
  localparam int ENTRIES_DEF = 64;

  localparam logic [OpW-1:0] OP_ENTRY = 2'd0;
  localparam logic [OpW-1:0] OP_POOL  = 2'd1;
  localparam logic [OpW-1:0] OP_GET   = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [PoolW-1:0]   pool;
    logic [CoreW-1:0]   core;
    logic [EntryW-1:0]  entry;
    logic [AddrW-1:0]   address_high;
    logic [AddrW-1:0]   address_low;
    logic [WeightW-1:0] weight;
    logic [PortW-1:0]   dest_port;
    logic [TotalW-1:0]  entry_total;
    logic               ipv6_mark;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]  sel_address_high;
    logic [AddrW-1:0]  sel_address_low;
    logic [PortW-1:0]  sel_port;
    logic              sel_ipv6;
    logic [EntryW-1:0] sel_entry;
    logic              pool_empty;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0]   addr_high;
    logic [AddrW-1:0]   addr_low;
    logic [WeightW-1:0] weight_set;
    logic [WeightW-1:0] weight_left;
  } entry_t;

endpackage

// File: sv/wrrap_req_if.sv
// Request channel of the address pool: valid/ready handshake with a req_t payload.
// Depends on wrrap_pkg.
interface wrrap_req_if;
  logic              valid;
  logic              ready;
  wrrap_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/wrrap_rsp_if.sv
// Response channel of the address pool: valid/ready handshake with a rsp_t payload.
// Depends on wrrap_pkg.
interface wrrap_rsp_if;
  logic              valid;
  logic              ready;
  wrrap_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/wrrap_entry_mem.sv
// Entry memory: address halves and weights of every pool entry.
// One write and one read port, registered read data. Depends on wrrap_pkg.
module wrrap_entry_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  wrrap_pkg::entry_t   wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output wrrap_pkg::entry_t   rdata_o
);

  wrrap_pkg::entry_t mem [DEPTH];
  wrrap_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/wrrap_pool_mem.sv
// Pool table: pointer, count, port and IPv6 flag of every pool/core slot.
// Per-entry valid bits make unwritten slots read as zero. Depends on nothing.
module wrrap_pool_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/weighted_round_robin_address_pool_core.sv
// A get runs through the execute, pool-read and entry-read states before its result is
// registered; an empty or out-of-range pool skips the entry read. Writes update the tables
// from the execute state. One item is handled at a time: a new request is taken only in the
// idle state, and a result that waits for the receiver holds the core; the order is set by
// the pool table read followed by the entry memory read-modify-write of that item.
// Reset: asynchronous, clears the control state and the pool table valid bits at once.
module weighted_round_robin_address_pool_core #(
  parameter int POOLS   = wrrap_pkg::POOLS_DEF,
  parameter int CORES   = wrrap_pkg::CORES_DEF,
  parameter int ENTRIES = wrrap_pkg::ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrrap_req_if.sink   req_i,
  wrrap_rsp_if.source rsp_o
);

  localparam int SLOTS = POOLS * CORES;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NENT  = SLOTS * ENTRIES;
  localparam int EW    = $clog2(NENT);
  localparam int PW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int PMW   = PW + CW + wrrap_pkg::PortW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POOL = 2'd2;
  localparam logic [1:0] S_ENT  = 2'd3;

  logic [1:0]        state_q, state_d;
  wrrap_pkg::req_t   item_q;
  wrrap_pkg::rsp_t   rsp_q, rsp_d;
  logic              rsp_vld_q, rsp_vld_d;

  logic              slot_ok, entry_ok, out_free, left_low;
  logic [SW-1:0]     slot;
  logic [EW-1:0]     ent_idx, ent_addr;
  logic [CW-1:0]     cnt_sat, cur_c, nxt_c, nxt_wrap;

  logic              ent_we, ent_re, pool_we, pool_re;
  wrrap_pkg::entry_t ent_wdata, ent_rd;
  logic [PMW-1:0]    pool_wdata, pool_rd;

  logic [PW-1:0]                 p_ptr;
  logic [CW-1:0]                 p_cnt;
  logic [wrrap_pkg::PortW-1:0]   p_port;
  logic                          p_v6;

  assign {p_ptr, p_cnt, p_port, p_v6} = pool_rd;

  assign slot_ok  = (32'(item_q.pool) < 32'(POOLS)) && (32'(item_q.core) < 32'(CORES));
  assign entry_ok = 32'(item_q.entry) < 32'(ENTRIES);
  assign slot     = SW'(item_q.pool) * SW'(CORES) + SW'(item_q.core);
  assign cnt_sat  = (32'(item_q.entry_total) > 32'(ENTRIES)) ? CW'(ENTRIES)
                                                             : CW'(item_q.entry_total);

  // A stale pointer at or past the count restarts the pool at entry zero.
  assign cur_c    = (CW'(p_ptr) >= p_cnt) ? '0 : CW'(p_ptr);
  assign nxt_c    = cur_c + CW'(1);
  assign nxt_wrap = (nxt_c >= p_cnt) ? '0 : nxt_c;
  assign left_low = ent_rd.weight_left <= wrrap_pkg::WeightW'(1);

  assign ent_idx  = (state_q == S_EXEC) ? EW'(item_q.entry) : EW'(cur_c);
  assign ent_addr = EW'(slot) * EW'(ENTRIES) + ent_idx;

  assign out_free = !rsp_vld_q || rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    rsp_d      = rsp_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_wdata  = ent_rd;
    pool_we    = 1'b0;
    pool_re    = 1'b0;
    pool_wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (item_q.op)
          wrrap_pkg::OP_ENTRY: begin
            ent_we                = slot_ok && entry_ok;
            ent_wdata.addr_high   = item_q.address_high;
            ent_wdata.addr_low    = item_q.address_low;
            ent_wdata.weight_set  = item_q.weight;
            ent_wdata.weight_left = item_q.weight;
          end
          wrrap_pkg::OP_POOL: begin
            pool_we    = slot_ok;
            pool_wdata = {PW'(0), cnt_sat, item_q.dest_port, item_q.ipv6_mark};
          end
          wrrap_pkg::OP_GET: begin
            pool_re = 1'b1;
            state_d = S_POOL;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POOL: begin
        if (!slot_ok || p_cnt == '0) begin
          if (out_free) begin
            rsp_d            = '0;
            rsp_d.pool_empty = 1'b1;
            rsp_vld_d        = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          ent_re  = 1'b1;
          state_d = S_ENT;
        end
      end
      S_ENT: begin
        // Read data of both memories holds here until the result register frees up.
        if (out_free) begin
          rsp_d                  = '0;
          rsp_d.sel_address_high = ent_rd.addr_high;
          rsp_d.sel_address_low  = ent_rd.addr_low;
          rsp_d.sel_port         = p_port;
          rsp_d.sel_ipv6         = p_v6;
          rsp_d.sel_entry        = wrrap_pkg::EntryW'(cur_c);
          rsp_vld_d              = 1'b1;
          ent_we                 = 1'b1;
          ent_wdata.weight_left  = left_low ? ent_rd.weight_set
                                            : ent_rd.weight_left - wrrap_pkg::WeightW'(1);
          pool_we                = 1'b1;
          pool_wdata             = {left_low ? PW'(nxt_wrap) : PW'(cur_c),
                                    p_cnt, p_port, p_v6};
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q <= req_i.data;
    end
    rsp_q <= rsp_d;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  wrrap_pool_mem #(
    .DEPTH (SLOTS),
    .AW    (SW),
    .DW    (PMW)
  ) u_pool_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pool_we),
    .waddr_i (slot),
    .wdata_i (pool_wdata),
    .re_i    (pool_re),
    .raddr_i (slot),
    .rdata_o (pool_rd)
  );

  wrrap_entry_mem #(
    .DEPTH (NENT),
    .AW    (EW)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_addr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_addr),
    .rdata_o (ent_rd)
  );

endmodule

// File: sv/wrrap_checker.sv
// Port-level checker of the address pool core, bound to the top level.
// Depends on wrrap_pkg and weighted_round_robin_address_pool_core.
module wrrap_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic [wrrap_pkg::OpW-1:0]   req_op_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input wrrap_pkg::rsp_t             rsp_data_i
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response changed while stalled");

  // An empty pool answers with all other fields zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.pool_empty |->
      rsp_data_i.sel_address_high == '0 && rsp_data_i.sel_address_low == '0 &&
      rsp_data_i.sel_port == '0 && rsp_data_i.sel_ipv6 == 1'b0 &&
      rsp_data_i.sel_entry == '0)
    else $error("empty response carries data");

  // Write transactions never produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_op_i != wrrap_pkg::OP_GET |=> !$rose(rsp_valid_i))
    else $error("result after a write transaction");

  // The core works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

endmodule

bind weighted_round_robin_address_pool_core wrrap_checker u_wrrap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_op_i    (req_i.data.op),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: tb/sv/weighted_round_robin_address_pool_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the weighted round-robin address pool core.
// Needs wrrap_pkg, wrrap_req_if, wrrap_rsp_if and the core; reads no files.
module weighted_round_robin_address_pool_core_tb;
  import wrrap_pkg::*;

  localparam int POOLS       = POOLS_DEF;
  localparam int CORES       = CORES_DEF;
  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int SLOTS       = POOLS * CORES;
  localparam int CELLS       = SLOTS * ENTRIES;
  localparam int ITEM_TARGET = 1550;
  localparam int STALL_AT    = 600;
  localparam int DRAIN_AT    = 1100;
  localparam int LONG_STALL  = 400;

  // The one opcode the block ignores.
  localparam logic [OpW-1:0] OP_IGNORED = 2'd3;

  localparam rsp_t NO_PICK = '{64'd0, 64'd0, 16'd0, 1'b0, 6'd0, 1'b1};

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  wrrap_req_if req_bus ();
  wrrap_rsp_if rsp_bus ();

  weighted_round_robin_address_pool_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Mirror of the pool tables and entry memories.
  bit [AddrW-1:0]   mir_addr_hi   [CELLS];
  bit [AddrW-1:0]   mir_addr_lo   [CELLS];
  bit [WeightW-1:0] mir_wgt_set   [CELLS];
  bit [WeightW-1:0] mir_wgt_left  [CELLS];
  bit               mir_written   [CELLS];
  bit [EntryW-1:0]  mir_pointer   [SLOTS];
  bit [TotalW-1:0]  mir_count     [SLOTS];
  bit [PortW-1:0]   mir_port      [SLOTS];
  bit               mir_ipv6      [SLOTS];

  rsp_t expected_picks[$];
  req_t plan_q[$];
  row_t directed_rows[$];

  int picks_open    = 0;
  int items_sent    = 0;
  int picks_seen    = 0;
  int empties_seen  = 0;
  int bursts_made   = 0;
  int mismatches    = 0;
  int hold_cnt      = 0;
  bit stall_request = 1'b0;

  // Applies one transaction to the mirror; returns 1 when it yields a pick.
  function automatic bit serve_lookup(input req_t r, output rsp_t pick);
    bit ok;
    int slot;
    int idx;
    int nxt;
    logic [EntryW-1:0] cur;
    pick = '0;
    ok   = (r.pool < POOLS) && (r.core < CORES);
    slot = ok ? r.pool * CORES + r.core : 0;
    case (r.op)
      OP_ENTRY: begin
        if (ok && r.entry < ENTRIES) begin
          idx = slot * ENTRIES + r.entry;
          mir_addr_hi[idx]  = r.address_high;
          mir_addr_lo[idx]  = r.address_low;
          mir_wgt_set[idx]  = r.weight;
          mir_wgt_left[idx] = r.weight;
          mir_written[idx]  = 1'b1;
        end
        return 1'b0;
      end
      OP_POOL: begin
        if (ok) begin
          mir_count[slot]   = (r.entry_total > ENTRIES) ? TotalW'(ENTRIES) : r.entry_total;
          mir_port[slot]    = r.dest_port;
          mir_ipv6[slot]    = r.ipv6_mark;
          mir_pointer[slot] = '0;
        end
        return 1'b0;
      end
      OP_GET: begin
        if (!ok || mir_count[slot] == 0) begin
          pick.pool_empty = 1'b1;
          return 1'b1;
        end
        cur = (mir_pointer[slot] >= mir_count[slot]) ? '0 : mir_pointer[slot];
        idx = slot * ENTRIES + cur;
        pick.sel_address_high = mir_addr_hi[idx];
        pick.sel_address_low  = mir_addr_lo[idx];
        pick.sel_port         = mir_port[slot];
        pick.sel_ipv6         = mir_ipv6[slot];
        pick.sel_entry        = cur;
        nxt = cur;
        if (mir_wgt_left[idx] <= 1) begin
          mir_wgt_left[idx] = mir_wgt_set[idx];
          nxt = cur + 1;
          if (nxt >= mir_count[slot]) nxt = 0;
        end else begin
          mir_wgt_left[idx] = mir_wgt_left[idx] - 1'b1;
        end
        mir_pointer[slot] = EntryW'(nxt);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A get must never land on an entry that was never written; such a get
  // is turned into a write of exactly that entry.
  function automatic req_t steer_to_written(input req_t r);
    int slot;
    int idx;
    logic [EntryW-1:0] cur;
    if (r.op == OP_GET && r.pool < POOLS && r.core < CORES) begin
      slot = r.pool * CORES + r.core;
      if (mir_count[slot] != 0) begin
        cur = (mir_pointer[slot] >= mir_count[slot]) ? '0 : mir_pointer[slot];
        idx = slot * ENTRIES + cur;
        if (!mir_written[idx]) begin
          r.op     = OP_ENTRY;
          r.entry  = cur;
          r.weight = WeightW'($urandom_range(0, 3));
        end
      end
    end
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.op           = OpW'($urandom);
    r.pool         = PoolW'($urandom);
    r.core         = CoreW'($urandom);
    r.entry        = EntryW'($urandom);
    r.address_high = {$urandom, $urandom};
    r.address_low  = {$urandom, $urandom};
    r.weight       = WeightW'($urandom);
    r.dest_port    = PortW'($urandom);
    r.entry_total  = TotalW'($urandom);
    r.ipv6_mark    = 1'($urandom);
    return r;
  endfunction

  // Most traffic goes to a handful of pools so that pointers wrap and weights drain.
  function automatic void pick_slot(output logic [PoolW-1:0] p, output logic [CoreW-1:0] c);
    int sel;
    if ($urandom_range(0, 9) < 6) begin
      sel = $urandom_range(0, 2);
      p = (sel == 0) ? PoolW'(0) : (sel == 1) ? PoolW'(1) : PoolW'(POOLS - 1);
      c = $urandom_range(0, 1) ? CoreW'(CORES - 1) : CoreW'(0);
    end else begin
      p = PoolW'($urandom);
      c = CoreW'($urandom);
    end
  endfunction

  // Fill a pool, set its count and then read it a number of times.
  function automatic void plan_burst();
    req_t r;
    int n;
    int gets;
    int i;
    bit wide;
    logic [PoolW-1:0] p;
    logic [CoreW-1:0] c;
    pick_slot(p, c);
    wide = ($urandom_range(0, 19) == 0);
    n    = wide ? ENTRIES : $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      r = random_req();
      r.op    = OP_ENTRY;
      r.pool  = p;
      r.core  = c;
      r.entry = EntryW'(i);
      if (wide) r.weight = WeightW'($urandom_range(0, 1));
      else if ($urandom_range(0, 6) != 0) r.weight = WeightW'($urandom_range(0, 3));
      plan_q.push_back(r);
    end
    r = random_req();
    r.op          = OP_POOL;
    r.pool        = p;
    r.core        = c;
    r.entry_total = wide ? TotalW'($urandom_range(ENTRIES, 127)) : TotalW'(n);
    plan_q.push_back(r);
    gets = wide ? ENTRIES + $urandom_range(2, 6) : $urandom_range(1, 12);
    for (i = 0; i < gets; i++) begin
      r = random_req();
      r.op   = OP_GET;
      r.pool = p;
      r.core = c;
      plan_q.push_back(r);
    end
    bursts_made++;
  endfunction

  // Loose transactions: any opcode, any field, including the ignored opcode.
  function automatic void plan_noise();
    req_t r;
    int n;
    int i;
    logic [PoolW-1:0] p;
    logic [CoreW-1:0] c;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      r = random_req();
      if ($urandom_range(0, 1) == 0) begin
        pick_slot(p, c);
        r.op   = OP_GET;
        r.pool = p;
        r.core = c;
      end
      plan_q.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic [OpW-1:0] op, input int pool, input int core,
                                  input int entry, input logic [AddrW-1:0] ah,
                                  input logic [AddrW-1:0] al, input int wgt, input int port,
                                  input int total, input bit v6, input bit typed,
                                  input rsp_t want);
    row_t row;
    row.req.op           = op;
    row.req.pool         = PoolW'(pool);
    row.req.core         = CoreW'(core);
    row.req.entry        = EntryW'(entry);
    row.req.address_high = ah;
    row.req.address_low  = al;
    row.req.weight       = WeightW'(wgt);
    row.req.dest_port    = PortW'(port);
    row.req.entry_total  = TotalW'(total);
    row.req.ipv6_mark    = v6;
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  task automatic check_pick(input rsp_t got);
    rsp_t want;
    if (picks_open == 0) begin
      note_mismatch("result with nothing pending", 64'd0, got.sel_address_low);
      return;
    end
    want = expected_picks.pop_front();
    picks_open--;
    if (got.sel_address_high !== want.sel_address_high)
      note_mismatch("sel_address_high", want.sel_address_high, got.sel_address_high);
    if (got.sel_address_low !== want.sel_address_low)
      note_mismatch("sel_address_low", want.sel_address_low, got.sel_address_low);
    if (got.sel_port !== want.sel_port)
      note_mismatch("sel_port", 64'(want.sel_port), 64'(got.sel_port));
    if (got.sel_ipv6 !== want.sel_ipv6)
      note_mismatch("sel_ipv6", 64'(want.sel_ipv6), 64'(got.sel_ipv6));
    if (got.sel_entry !== want.sel_entry)
      note_mismatch("sel_entry", 64'(want.sel_entry), 64'(got.sel_entry));
    if (got.pool_empty !== want.pool_empty)
      note_mismatch("pool_empty", 64'(want.pool_empty), 64'(got.pool_empty));
  endtask

  // Offers one transaction after a random gap and waits for it to be taken.
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    int gap;
    bit quiet;
    bit has_pick;
    rsp_t pick;
    quiet = (((items_sent / 128) % 4) == 3) || (hold_cnt > 0);
    gap   = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    items_sent++;
    has_pick = serve_lookup(r, pick);
    if (has_pick) begin
      expected_picks.push_back(typed ? want : pick);
      picks_open++;
    end
  endtask

  // Receiver: random hold-off per result, steady stretches and one long stall.
  initial begin
    int wait_left;
    bit steady;
    wait_left = 0;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        check_pick(rsp_bus.data);
        picks_seen++;
        if (rsp_bus.data.pool_empty) empties_seen++;
        steady    = ((picks_seen / 64) % 4) == 2;
        wait_left = steady ? 0 : $urandom_range(0, 5);
      end
      if (stall_request) begin
        stall_request = 1'b0;
        hold_cnt      = LONG_STALL;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_bus.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", picks_open);
    $display("simulation failed");
    $finish;
  end

  initial begin
    req_t r;
    int i;
    int n_directed;
    rst_ni        <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;

    // Empty pool straight after reset, then the ignored opcode.
    add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b1, NO_PICK);
    add_row(OP_IGNORED, 31, 7, 63, '1, '1, 16'hFFFF, 16'hFFFF, 127, 1'b1, 1'b0, NO_PICK);
    // Three entries with weights 2, 0 (served once) and 1, then rotate through them.
    add_row(OP_ENTRY, 0, 0, 0, 64'd0, 64'd0, 2, 0, 0, 1'b0, 1'b0, NO_PICK);
    add_row(OP_ENTRY, 0, 0, 1, '1, '1, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    add_row(OP_ENTRY, 0, 0, 2, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1, 0, 0,
            1'b0, 1'b0, NO_PICK);
    add_row(OP_POOL, 0, 0, 0, 64'd0, 64'd0, 0, 0, 3, 1'b0, 1'b0, NO_PICK);
    add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b1,
            '{64'd0, 64'd0, 16'd0, 1'b0, 6'd0, 1'b0});
    for (i = 0; i < 5; i++)
      add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    // Rewriting the pool rewinds its pointer but keeps the remaining weights.
    add_row(OP_POOL, 0, 0, 0, 64'd0, 64'd0, 0, 16'hFFFF, 3, 1'b1, 1'b0, NO_PICK);
    add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    // Last pool and core, top entry slot, top weight, count saturating at the maximum.
    add_row(OP_ENTRY, 31, 7, 63, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
            16'hFFFF, 0, 0, 1'b0, 1'b0, NO_PICK);
    add_row(OP_ENTRY, 31, 7, 0, '1, '1, 16'hFFFF, 0, 0, 1'b0, 1'b0, NO_PICK);
    add_row(OP_POOL, 31, 7, 0, 64'd0, 64'd0, 0, 16'h1234, 127, 1'b1, 1'b0, NO_PICK);
    add_row(OP_GET, 31, 7, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b1,
            '{'1, '1, 16'h1234, 1'b1, 6'd0, 1'b0});
    add_row(OP_GET, 31, 7, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    // A count of zero empties the pool again.
    add_row(OP_POOL, 31, 7, 0, 64'd0, 64'd0, 0, 16'hFFFF, 0, 1'b1, 1'b0, NO_PICK);
    add_row(OP_GET, 31, 7, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b1, NO_PICK);
    add_row(OP_POOL, 0, 0, 0, 64'd0, 64'd0, 0, 16'h8000, 64, 1'b0, 1'b0, NO_PICK);
    add_row(OP_GET, 0, 0, 0, 64'd0, 64'd0, 0, 0, 0, 1'b0, 1'b0, NO_PICK);
    n_directed = directed_rows.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < n_directed; i++) begin
      if (directed_rows[i].typed)
        send_req(directed_rows[i].req, 1'b1, directed_rows[i].want);
      else
        send_req(steer_to_written(directed_rows[i].req), 1'b0, NO_PICK);
    end

    while (items_sent < ITEM_TARGET) begin
      if (plan_q.size() == 0) begin
        if ($urandom_range(0, 99) < 70) plan_burst();
        else plan_noise();
      end
      if (items_sent == STALL_AT) stall_request = 1'b1;
      if (items_sent == DRAIN_AT) begin
        // Let the block run dry before continuing.
        req_bus.valid <= 1'b0;
        wait (picks_open == 0);
        @(posedge clk_i);
      end
      r = steer_to_written(plan_q.pop_front());
      send_req(r, 1'b0, NO_PICK);
    end
    req_bus.valid <= 1'b0;

    wait (picks_open == 0);
    repeat (20) @(posedge clk_i);
    if (expected_picks.size() != 0)
      note_mismatch("results still pending", 64'd0, 64'(expected_picks.size()));

    $display("sent %0d requests (%0d directed, %0d pool fill bursts)",
             items_sent, n_directed, bursts_made);
    $display("checked %0d lookups, %0d of them on empty pools, %0d mismatches",
             picks_seen, empties_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
